>>> hdl/assert_macros.svh
// assertion macros used by the translator rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property check, clocked, off while reset is asserted
`define PCT_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// same-cycle implication
`define PCT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PCT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/pct_pkg.sv
// types, constants and helper functions for the particle code translator
`timescale 1ns / 1ps
`default_nettype none

package pct_pkg;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_ZERO   = 3'd1,
        ST_BIG    = 3'd2,
        ST_EXOTIC = 3'd3,
        ST_NONE   = 3'd4
    } t_status;

    typedef logic signed [31:0] t_src_code;
    typedef logic signed [30:0] t_std_code;

    localparam logic [31:0] MAG_LIMIT   = 32'd1000000000;
    // reciprocal constants: floor(x * RECIP >> SHIFT) == floor(x / divisor)
    localparam logic [29:0] RECIP_1E4   = 30'd879609303;
    localparam int          SHIFT_1E4   = 43;
    localparam logic [17:0] RECIP_100_L = 18'd167773;
    localparam logic [12:0] RECIP_100_S = 13'd5243;
    localparam logic [7:0]  RECIP_10    = 8'd205;

    // floor(x / 10) for x below 1000
    function automatic logic [6:0] pct_div10(input logic [9:0] x);
        logic [17:0] p;
        p = 18'(x) * 18'(RECIP_10);
        return p[17:11];
    endfunction

    // fixed lookup for magnitudes 1..100, indexed by magnitude minus one
    function automatic logic [23:0] pct_low_entry(input logic [6:0] idx);
        logic [23:0] v;
        v = 24'd0;
        if ((idx <= 7'd7) || (idx >= 7'd10 && idx <= 7'd17) ||
            (idx >= 7'd20 && idx <= 7'd24) || (idx >= 7'd31 && idx <= 7'd36) ||
            (idx >= 7'd80 && idx <= 7'd98)) begin
            v = 24'(idx) + 24'd1;
        end else begin
            case (idx)
                7'd27:   v = 24'd110;
                7'd28:   v = 24'd990;
                7'd37:   v = 24'd3000221;
                7'd38:   v = 24'd42;
                7'd39:   v = 24'd41;
                7'd50:   v = 24'd3000111;
                7'd51:   v = 24'd3000211;
                7'd52:   v = 24'd3100111;
                7'd53:   v = 24'd3000113;
                7'd54:   v = 24'd3000213;
                7'd55:   v = 24'd3000223;
                7'd60:   v = 24'd9900041;
                7'd61:   v = 24'd9900042;
                7'd62:   v = 24'd9900024;
                7'd63:   v = 24'd9900012;
                7'd64:   v = 24'd9900014;
                7'd65:   v = 24'd9900016;
                default: v = 24'd0;
            endcase
        end
        return v;
    endfunction

    // table values whose negative has no antiparticle
    function automatic logic pct_no_anti(input logic [23:0] v);
        return (v == 24'd10) || (v == 24'd21) || (v == 24'd22) || (v == 24'd23) ||
               (v == 24'd25) || (v == 24'd32) || (v == 24'd33) || (v == 24'd35) ||
               (v == 24'd36) || (v == 24'd81) || (v == 24'd83) ||
               (v >= 24'd91 && v <= 24'd99);
    endfunction

endpackage

`default_nettype wire

>>> hdl/pct_stream_if.sv
// valid/ready channels for source codes and translated results
`timescale 1ns / 1ps
`default_nettype none

interface pct_in_if import pct_pkg::*; ();
    logic      valid;
    logic      ready;
    t_src_code source_code;

    modport source (output valid, output source_code, input ready);
    modport sink (input valid, input source_code, output ready);
endinterface

interface pct_out_if import pct_pkg::*; ();
    logic      valid;
    logic      ready;
    t_std_code standard_code;
    t_status   status;

    modport source (output valid, output standard_code, output status, input ready);
    modport sink (input valid, input standard_code, input status, output ready);
endinterface

`default_nettype wire

>>> hdl/particle_code_translate.sv
// Particle code translator: maps one signed source-numbering code per item to the standard
// numbering, with a status. Fully pipelined: one item is taken every cycle unless a full
// pipe is stalled by the output, and each item passes through the input register, three
// stages of reciprocal multiplies that pull out the decimal digits and the result register.
// Each stage holds its item only while the stage after it is full and stalled, so bubbles are
// squeezed out and the input keeps taking items while a finished result waits on the output.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module particle_code_translate import pct_pkg::*; (
    input  wire          i_clk,
    input  wire          i_rst_n,
    pct_in_if.sink       i_src,
    pct_out_if.source    o_res
);

    // stage enables
    logic en0, en1, en2, en3, en4;

    // stage 0: input register
    logic        r_v0;
    t_src_code   r_code0;

    // stage 1: magnitude and magnitude / 1e4
    logic        r_v1, r_neg1, r_big1;
    logic [29:0] r_mag1;
    logic [16:0] r_q4_1;
    logic [31:0] n_mag32;
    logic [59:0] n_prod1;

    // stage 2: low four digits and magnitude / 1e6
    logic        r_v2, r_neg2, r_big2;
    logic [29:0] r_mag2;
    logic [13:0] r_r4_2;
    logic [9:0]  r_q6_2;
    logic [29:0] n_t2, n_r4full;
    logic [34:0] n_prod6;

    // stage 3: two-digit halves and class digit
    logic        r_v3, r_neg3, r_big3;
    logic [29:0] r_mag3;
    logic [6:0]  r_hi3, r_lo3;
    logic [3:0]  r_cls3;
    logic [26:0] n_prodh;
    logic [6:0]  n_hi, n_q6d;
    logic [13:0] n_lo14;
    logic [9:0]  n_cls10;

    // stage 4: result register
    logic        r_v4;
    t_std_code   r_code4;
    t_status     r_st4;
    t_std_code   n_code;
    t_status     n_st;

    // decision logic
    logic [6:0]  q_d1, q_d3;
    logic [3:0]  d0, d1, d2, d3;
    logic [6:0]  rem_lo, rem_hi;
    logic [29:0] mag_m1;
    logic [23:0] tbl;
    logic [23:0] sp_mag;
    logic        sp_hit;
    t_std_code   code_s, tbl_s, sp_s;

    assign en4 = !r_v4 || o_res.ready;
    assign en3 = !r_v3 || en4;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;
    assign en0 = !r_v0 || en1;

    assign i_src.ready         = en0;
    assign o_res.valid         = r_v4;
    assign o_res.standard_code = r_code4;
    assign o_res.status        = r_st4;

    // stage 1 math
    always_comb begin
        n_mag32 = r_code0[31] ? (~r_code0 + 32'd1) : r_code0;
        n_prod1 = 60'(n_mag32[29:0]) * 60'(RECIP_1E4);
    end

    // stage 2 math
    always_comb begin
        n_t2     = 30'(r_q4_1) * 30'd10000;
        n_r4full = r_mag1 - n_t2;
        n_prod6  = 35'(r_q4_1) * 35'(RECIP_100_L);
    end

    // stage 3 math
    always_comb begin
        n_prodh = 27'(r_r4_2) * 27'(RECIP_100_S);
        n_hi    = n_prodh[25:19];
        n_lo14  = r_r4_2 - 14'(n_hi) * 14'd100;
        n_q6d   = pct_div10(r_q6_2);
        n_cls10 = r_q6_2 - 10'(n_q6d) * 10'd10;
    end

    // stage 4: digit split and translation rules
    always_comb begin
        q_d1   = pct_div10({3'b000, r_lo3});
        q_d3   = pct_div10({3'b000, r_hi3});
        d1     = q_d1[3:0];
        d3     = q_d3[3:0];
        rem_lo = r_lo3 - 7'(d1) * 7'd10;
        rem_hi = r_hi3 - 7'(d3) * 7'd10;
        d0     = rem_lo[3:0];
        d2     = rem_hi[3:0];

        code_s = r_neg3 ? -(31'(r_mag3)) : 31'(r_mag3);
        mag_m1 = r_mag3 - 30'd1;
        tbl    = pct_low_entry(mag_m1[6:0]);
        tbl_s  = r_neg3 ? -(31'(tbl)) : 31'(tbl);

        // special codes ending in zero; the sign follows the input where allowed
        sp_hit = 1'b1;
        sp_mag = 24'd0;
        if (r_mag3 == 30'd110 && !r_neg3)       sp_mag = 24'd9910113;
        else if (r_mag3 == 30'd210)             sp_mag = 24'd9910211;
        else if (r_mag3 == 30'd220 && !r_neg3)  sp_mag = 24'd9910223;
        else if (r_mag3 == 30'd330 && !r_neg3)  sp_mag = 24'd9910333;
        else if (r_mag3 == 30'd440 && !r_neg3)  sp_mag = 24'd9910443;
        else if (r_mag3 == 30'd2110)            sp_mag = 24'd9912112;
        else if (r_mag3 == 30'd2210)            sp_mag = 24'd9912212;
        else if (r_mag3 == 30'd130 && !r_neg3)  sp_mag = 24'd130;
        else if (r_mag3 == 30'd310 && !r_neg3)  sp_mag = 24'd310;
        else                                    sp_hit = 1'b0;
        sp_s = r_neg3 ? -(31'(sp_mag)) : 31'(sp_mag);

        n_st   = ST_NONE;
        n_code = '0;
        // big first: the kept low magnitude bits read as zero at 2^30 and 2^31
        if (r_big3) begin
            n_st = ST_BIG;
        end else if (r_mag3 == 30'd0) begin
            n_st = ST_ZERO;
        end else if (r_cls3 == 4'd1 || r_cls3 == 4'd2 || r_cls3 == 4'd4) begin
            n_st   = ST_OK;
            n_code = code_s;
        end else if (r_cls3 == 4'd3 || r_cls3 == 4'd5) begin
            n_st = ST_EXOTIC;
        end else if (r_mag3 <= 30'd100) begin
            if (tbl != 24'd0 && !(r_neg3 && pct_no_anti(tbl))) begin
                n_st   = ST_OK;
                n_code = tbl_s;
            end
        end else if (d0 == 4'd0) begin
            if (sp_hit) begin
                n_st   = ST_OK;
                n_code = sp_s;
            end
        end else if (d1 != 4'd0 && d3 != 4'd0 && (d0 == 4'd2 || d0 == 4'd4)) begin
            n_st   = ST_OK;
            n_code = code_s;
        end else if (d1 != 4'd0 && d2 != 4'd0 && d3 == 4'd0) begin
            // meson remaps
            n_st = ST_OK;
            if (r_mag3 == 30'd10111 && !r_neg3)      n_code = 31'sd9000111;
            else if (r_mag3 == 30'd10211)            n_code = r_neg3 ? -31'sd9000211
                                                                     : 31'sd9000211;
            else if (r_mag3 == 30'd10221 && !r_neg3) n_code = 31'sd9010221;
            else if (r_mag3 == 30'd10331 && !r_neg3) n_code = 31'sd10221;
            else if (d1 == d2 && r_neg3)             n_st   = ST_NONE;
            else                                     n_code = code_s;
        end else if (d2 != 4'd0 && d3 != 4'd0 && d1 == 4'd0) begin
            // diquarks
            if (!(d2 == d3 && r_neg3)) begin
                n_st   = ST_OK;
                n_code = code_s;
            end
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (en0) r_v0 <= i_src.valid;
            if (en1) r_v1 <= r_v0;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (en0) begin
            r_code0 <= i_src.source_code;
        end
        if (en1) begin
            r_neg1 <= r_code0[31];
            r_big1 <= (n_mag32 >= MAG_LIMIT);
            r_mag1 <= n_mag32[29:0];
            r_q4_1 <= n_prod1[59:SHIFT_1E4];
        end
        if (en2) begin
            r_neg2 <= r_neg1;
            r_big2 <= r_big1;
            r_mag2 <= r_mag1;
            r_r4_2 <= n_r4full[13:0];
            r_q6_2 <= n_prod6[33:24];
        end
        if (en3) begin
            r_neg3 <= r_neg2;
            r_big3 <= r_big2;
            r_mag3 <= r_mag2;
            r_hi3  <= n_hi;
            r_lo3  <= n_lo14[6:0];
            r_cls3 <= n_cls10[3:0];
        end
        if (en4) begin
            r_code4 <= n_code;
            r_st4   <= n_st;
        end
    end

    // a rejected item never carries a code, an accepted one always does
    `PCT_ASSERT_IMP(a_code_zero_on_reject, i_clk, i_rst_n, r_v4 && (r_st4 != ST_OK),
        r_code4 == '0, "nonzero code with failure status")
    `PCT_ASSERT_IMP(a_code_nonzero_on_ok, i_clk, i_rst_n, r_v4 && (r_st4 == ST_OK),
        r_code4 != '0, "zero code with ok status")
    // input only stalls once every stage is full
    `PCT_ASSERT_IMP(a_stall_only_full, i_clk, i_rst_n, !i_src.ready,
        r_v0 && r_v1 && r_v2 && r_v3 && r_v4, "input stalled with a bubble in the pipe")
    // an item waiting behind a stalled result is kept
    `PCT_ASSERT_NXT(a_hold_stage3, i_clk, i_rst_n, r_v3 && r_v4 && !o_res.ready,
        r_v3 && $stable(r_mag3), "stage 3 item lost during output stall")

endmodule

`default_nettype wire
